@@ design/pcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DEPTH    = 3'd0,
    REG_PALETTE  = 3'd1,
    REG_GAIN_R   = 3'd2,
    REG_GAIN_G   = 3'd3,
    REG_GAIN_B   = 3'd4,
    REG_CONTRAST = 3'd5,
    REG_BRIGHT   = 3'd6,
    REG_SAT      = 3'd7
  } reg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] PERCENT_UNITY = 8'd100;

  typedef struct packed {
    logic [1:0] color_depth_mode;
    logic [3:0] palette_limits;
    logic [7:0] gain_red;
    logic [7:0] gain_green;
    logic [7:0] gain_blue;
    logic [7:0] contrast_percent;
    logic [7:0] brightness_percent;
    logic [7:0] saturation_percent;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       transparent_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       transparent_out;
  } pix_out_t;

  // Request passed from the front to the back through the queue
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       transparent;
    logic       hsv;
  } item_t;

  localparam int QUEUE_DEPTH = 4;

  // Hue in 1/256 degree
  localparam logic [16:0] HUE_SECTOR = 17'd15360;
  localparam logic [16:0] HUE_120    = 17'd30720;
  localparam logic [16:0] HUE_180    = 17'd46080;
  localparam logic [16:0] HUE_240    = 17'd61440;
  localparam logic [16:0] HUE_300    = 17'd76800;
  localparam logic [16:0] HUE_360    = 17'd92160;

  // Reciprocals for division by constants: floor(x * K >> SH)
  localparam logic [16:0] K_GAIN  = 17'd83887;       // /100
  localparam int          SH_GAIN = 23;
  localparam logic [13:0] K_CON   = 14'd10486;       // /25 (after /8)
  localparam int          SH_CON  = 18;
  localparam logic [23:0] K_BRI   = 24'd10737419;    // /25
  localparam int          SH_BRI  = 28;
  localparam logic [29:0] K_CHR   = 30'd879609303;   // /625
  localparam int          SH_CHR  = 39;
  localparam logic [24:0] K_SEC   = 25'd17895698;    // /15 (after /1024)
  localparam int          SH_SEC  = 28;

endpackage

`default_nettype wire

@@ design/pcc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcc_front import pcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_data,
  output logic    push_valid,
  input  logic    push_ready,
  output item_t   push_data
);

  logic adv;
  logic [5:1] v_r;

  pix_in_t pix1_r, pix2_r, pix3_r, pix4_r, pix5_r;
  logic [15:0] x1_r [3];
  logic [15:0] x1_nxt [3];
  logic [32:0] x2_r [3];
  logic [32:0] x2_nxt [3];
  logic [7:0]  g3_r [3];
  logic [7:0]  g3_nxt [3];
  logic signed [18:0] n4_r [3];
  logic signed [18:0] n4_nxt [3];
  logic [27:0] y5_r [3];
  logic [27:0] y5_nxt [3];
  logic blk4_r, blk5_r;
  logic [7:0] c_val [3];

  assign adv        = !v_r[5] || push_ready;
  assign in_ready   = adv;
  assign push_valid = v_r[5];

  function automatic logic [7:0] quantize(input logic [1:0] mode, input logic [7:0] v);
    case (mode)
      2'd1:    return 8'({4'd0, v[7:4]} * 8'd17);
      2'd2:    return 8'({5'd0, v[7:5]} * 8'd36);
      2'd3:    return 8'({6'd0, v[7:6]} * 8'd85);
      default: return v;
    endcase
  endfunction

  function automatic logic [7:0] or_mask(input logic [1:0] s);
    case (s)
      2'd1:    return 8'h11;
      2'd2:    return 8'h22;
      2'd3:    return 8'h33;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] and_mask(input logic [1:0] s);
    case (s)
      2'd1:    return 8'hEE;
      2'd2:    return 8'hDD;
      2'd3:    return 8'hCC;
      default: return 8'hFF;
    endcase
  endfunction

  always_comb begin
    logic [7:0] chan [3];
    logic [7:0] gain [3];
    logic [7:0] m;
    logic [9:0] gt;
    logic signed [18:0] a;
    logic [9:0] ct;
    chan[0] = in_data.red_in;
    chan[1] = in_data.green_in;
    chan[2] = in_data.blue_in;
    gain[0] = cfg.gain_red;
    gain[1] = cfg.gain_green;
    gain[2] = cfg.gain_blue;
    for (int i = 0; i < 3; i++) begin
      // quantize, mask, scale by gain
      m = (quantize(cfg.color_depth_mode, chan[i]) | or_mask(cfg.palette_limits[1:0]))
          & and_mask(cfg.palette_limits[3:2]);
      x1_nxt[i] = {8'd0, m} * {8'd0, gain[i]};
      x2_nxt[i] = {17'd0, x1_r[i]} * {16'd0, K_GAIN};
      gt = x2_r[i][32:SH_GAIN];
      g3_nxt[i] = (gt > 10'd255) ? 8'hFF : gt[7:0];
      // contrast numerator: (2v - 255) * C + 25500
      a = $signed({10'd0, g3_r[i], 1'b0}) - 19'sd255;
      n4_nxt[i] = 19'(a * $signed({11'd0, cfg.contrast_percent})) + 19'sd25500;
      y5_nxt[i] = (n4_r[i] <= 19'sd0) ? 28'd0 : {14'd0, n4_r[i][16:3]} * {14'd0, K_CON};
      ct = y5_r[i][27:SH_CON];
      c_val[i] = (ct > 10'd255) ? 8'hFF : ct[7:0];
    end
  end

  always_comb begin
    push_data.transparent = pix5_r.transparent_in;
    if (pix5_r.transparent_in) begin
      push_data.red   = pix5_r.red_in;
      push_data.green = pix5_r.green_in;
      push_data.blue  = pix5_r.blue_in;
      push_data.hsv   = 1'b0;
    end else if (blk5_r) begin
      push_data.red   = 8'd0;
      push_data.green = 8'd0;
      push_data.blue  = 8'd0;
      push_data.hsv   = 1'b0;
    end else begin
      push_data.red   = c_val[0];
      push_data.green = c_val[1];
      push_data.blue  = c_val[2];
      push_data.hsv   = (cfg.brightness_percent != PERCENT_UNITY) ||
                        (cfg.saturation_percent != PERCENT_UNITY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1_r <= in_data;
      pix2_r <= pix1_r;
      pix3_r <= pix2_r;
      pix4_r <= pix3_r;
      pix5_r <= pix4_r;
      x1_r   <= x1_nxt;
      x2_r   <= x2_nxt;
      g3_r   <= g3_nxt;
      n4_r   <= n4_nxt;
      y5_r   <= y5_nxt;
      blk4_r <= (g3_r[0] == 8'd0) && (g3_r[1] == 8'd0) && (g3_r[2] == 8'd0);
      blk5_r <= blk4_r;
    end
  end

endmodule

`default_nettype wire

@@ design/pcc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue import pcc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/pcc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider; quotient must fit QW bits.
module pcc_div #(
  parameter int NW  = 22,
  parameter int DW  = 8,
  parameter int QW  = 14,
  parameter int BPS = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int ST = QW / BPS;

  logic [DW-1:0] rem_r [ST];
  logic [QW-1:0] low_r [ST];
  logic [QW-1:0] q_r   [ST];
  logic [DW-1:0] den_r [ST];

  for (genvar k = 0; k < ST; k++) begin : g_st
    logic [DW-1:0] rem_i, den_i, rem_o;
    logic [QW-1:0] low_i, q_i, low_o, q_o;

    if (k == 0) begin : g_in
      assign rem_i = num[NW-1:QW];
      assign low_i = num[QW-1:0];
      assign q_i   = '0;
      assign den_i = den;
    end else begin : g_prev
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
      assign den_i = den_r[k-1];
    end

    always_comb begin
      logic [DW:0] wide;
      rem_o = rem_i;
      low_o = low_i;
      q_o   = q_i;
      for (int b = 0; b < BPS; b++) begin
        wide  = {rem_o, low_o[QW-1]};
        low_o = {low_o[QW-2:0], 1'b0};
        q_o   = {q_o[QW-2:0], 1'b0};
        if (wide >= {1'b0, den_i}) begin
          wide   = wide - {1'b0, den_i};
          q_o[0] = 1'b1;
        end
        rem_o = wide[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_o;
        low_r[k] <= low_o;
        q_r[k]   <= q_o;
        den_r[k] <= den_i;
      end
    end
  end

  assign quo = q_r[ST-1];

endmodule

`default_nettype wire

@@ design/pcc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcc_back import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  item_t    pop_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_out_t out_data
);

  localparam int NS = 10;

  typedef struct packed {
    item_t              it;
    logic [7:0]         mx;
    logic [7:0]         d;
    logic               neg;
    logic [16:0]        base;
    logic [16:0]        p;
    logic [16:0]        w;
    logic [46:0]        brp;
    logic [24:0]        cd;
    logic [18:0]        bri;
    logic [58:0]        chp;
    logic [19:0]        chroma;
    logic signed [20:0] lo;
    logic [2:0]         sec;
    logic [33:0]        tp;
    logic [48:0]        yp;
  } bk_t;

  logic be;
  logic [NS:1] v_r;
  bk_t st_r   [1:NS];
  bk_t st_nxt [1:NS];
  logic [21:0] dnum_r, dnum_nxt;
  logic [7:0]  dden_r, dden_nxt;
  logic [13:0] quo;
  logic        out_valid_r;
  pix_out_t    out_data_r, out_nxt;

  assign be        = !out_valid_r || out_ready;
  assign pop_ready = be;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pcc_div #(.NW(22), .DW(8), .QW(14), .BPS(2)) u_div (
    .clk(clk),
    .en (be),
    .num(dnum_r),
    .den(dden_r),
    .quo(quo)
  );

  function automatic logic [7:0] clamp_fx(input logic signed [21:0] v);
    if (v < 22'sd0) begin
      return 8'd0;
    end else if (v[21:8] > 14'd255) begin
      return 8'hFF;
    end else begin
      return v[15:8];
    end
  endfunction

  always_comb begin
    logic [7:0]  r, g, b, mn, ad;
    logic signed [8:0] diff;
    logic [8:0]  lum;
    logic [16:0] hq, t;
    logic signed [21:0] mid, bri_s, lo_s;
    logic [19:0] m;
    // stage 1: max, min, hue operands, luminance products
    r = pop_data.red;
    g = pop_data.green;
    b = pop_data.blue;
    st_nxt[1] = st_r[1];
    st_nxt[1].it = pop_data;
    st_nxt[1].mx = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
    mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    st_nxt[1].d = st_nxt[1].mx - mn;
    if (g == st_nxt[1].mx) begin
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
      st_nxt[1].base = HUE_120;
    end else if (b == st_nxt[1].mx) begin
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
      st_nxt[1].base = HUE_240;
    end else begin
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
      st_nxt[1].base = (b > g) ? HUE_360 : 17'd0;
    end
    st_nxt[1].neg = diff[8];
    ad = diff[8] ? 8'(-diff) : diff[7:0];
    if (st_nxt[1].d == 8'd0) begin
      dnum_nxt = '0;
      dden_nxt = 8'd1;
    end else begin
      dnum_nxt = {14'd0, ad} * 22'(HUE_SECTOR);
      dden_nxt = st_nxt[1].d;
    end
    lum = (cfg.brightness_percent > PERCENT_UNITY) ?
          ({cfg.brightness_percent, 1'b0} - 9'(PERCENT_UNITY)) : {1'b0, cfg.brightness_percent};
    st_nxt[1].p = {8'd0, lum} * {9'd0, st_nxt[1].mx};
    st_nxt[1].w = {8'd0, lum} * {9'd0, cfg.saturation_percent};

    // stage 2: brightness product, chroma base
    st_nxt[2]     = st_r[1];
    st_nxt[2].brp = {24'd0, st_r[1].p, 6'd0} * {23'd0, K_BRI};
    st_nxt[2].cd  = {8'd0, st_r[1].w} * {17'd0, st_r[1].d};

    // stage 3: bri, chroma product
    st_nxt[3]     = st_r[2];
    st_nxt[3].bri = 19'(st_r[2].brp >> SH_BRI);
    st_nxt[3].chp = {30'd0, st_r[2].cd, 4'd0} * {29'd0, K_CHR};

    // stage 4: chroma and low level
    st_nxt[4]        = st_r[3];
    st_nxt[4].chroma = 20'(st_r[3].chp >> SH_CHR);
    st_nxt[4].lo     = $signed({2'b0, st_r[3].bri}) - $signed({1'b0, st_nxt[4].chroma});

    // stages 5 to 8: hold while the divider finishes
    for (int k = 5; k <= 8; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    // stage 9: hue, sector, ramp distance
    st_nxt[9] = st_r[8];
    hq = st_r[8].neg ? (st_r[8].base - {3'd0, quo}) : (st_r[8].base + {3'd0, quo});
    if (hq < HUE_SECTOR) begin
      st_nxt[9].sec = 3'd0;
      t = hq;
    end else if (hq < HUE_120) begin
      st_nxt[9].sec = 3'd1;
      t = HUE_120 - hq;
    end else if (hq < HUE_180) begin
      st_nxt[9].sec = 3'd2;
      t = hq - HUE_120;
    end else if (hq < HUE_240) begin
      st_nxt[9].sec = 3'd3;
      t = HUE_240 - hq;
    end else if (hq < HUE_300) begin
      st_nxt[9].sec = 3'd4;
      t = hq - HUE_240;
    end else begin
      st_nxt[9].sec = 3'd5;
      t = HUE_360 - hq;
    end
    st_nxt[9].tp = {20'd0, t[13:0]} * {14'd0, st_r[8].chroma};

    // stage 10: divide by the sector width
    st_nxt[10]    = st_r[9];
    st_nxt[10].yp = {25'd0, st_r[9].tp[33:10]} * {24'd0, K_SEC};

    // output: rebuild channels per sector and clamp, or pass bypass items through
    m     = 20'(st_r[10].yp >> SH_SEC);
    lo_s  = 22'(st_r[10].lo);
    bri_s = $signed({3'b0, st_r[10].bri});
    mid   = lo_s + $signed({2'b0, m});
    out_nxt.transparent_out = st_r[10].it.transparent;
    if (!st_r[10].it.hsv) begin
      out_nxt.red_out   = st_r[10].it.red;
      out_nxt.green_out = st_r[10].it.green;
      out_nxt.blue_out  = st_r[10].it.blue;
    end else begin
      case (st_r[10].sec)
        3'd0: begin
          out_nxt.red_out   = clamp_fx(bri_s);
          out_nxt.green_out = clamp_fx(mid);
          out_nxt.blue_out  = clamp_fx(lo_s);
        end
        3'd1: begin
          out_nxt.red_out   = clamp_fx(mid);
          out_nxt.green_out = clamp_fx(bri_s);
          out_nxt.blue_out  = clamp_fx(lo_s);
        end
        3'd2: begin
          out_nxt.red_out   = clamp_fx(lo_s);
          out_nxt.green_out = clamp_fx(bri_s);
          out_nxt.blue_out  = clamp_fx(mid);
        end
        3'd3: begin
          out_nxt.red_out   = clamp_fx(lo_s);
          out_nxt.green_out = clamp_fx(mid);
          out_nxt.blue_out  = clamp_fx(bri_s);
        end
        3'd4: begin
          out_nxt.red_out   = clamp_fx(mid);
          out_nxt.green_out = clamp_fx(lo_s);
          out_nxt.blue_out  = clamp_fx(bri_s);
        end
        default: begin
          out_nxt.red_out   = clamp_fx(bri_s);
          out_nxt.green_out = clamp_fx(lo_s);
          out_nxt.blue_out  = clamp_fx(mid);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      v_r         <= {v_r[NS-1:1], pop_valid};
      out_valid_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      st_r       <= st_nxt;
      dnum_r     <= dnum_nxt;
      dden_r     <= dden_nxt;
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/pixel_color_correction.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pixel colour correction. Takes one RGB pixel request per clock while in_ready is high, with a
// transparent flag, and returns one corrected pixel per request, in order. Transparent pixels
// come back unchanged; others are quantized, masked, scaled by per-channel gain, passed through
// the contrast curve and, when brightness or saturation differs from 100 percent, through an
// HSV round trip; pixels black after gain come out black. Sustained rate is one pixel per clock
// while out_ready stays high. Requests pass five front stages (gain and contrast multiplies),
// the queue, and ten back stages set by the seven-stage hue divider plus the HSV multiplies,
// then the result register. The front and back stall independently; the queue between them
// absorbs short stalls. Write configuration registers only while no request is in flight.
module pixel_color_correction import pcc_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pix_out_t              out_data,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_data, pop_data;

  // Configuration registers: hold until written, mask writes to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_depth_mode   <= 2'd0;
      cfg_r.palette_limits     <= 4'd0;
      cfg_r.gain_red           <= PERCENT_UNITY;
      cfg_r.gain_green         <= PERCENT_UNITY;
      cfg_r.gain_blue          <= PERCENT_UNITY;
      cfg_r.contrast_percent   <= PERCENT_UNITY;
      cfg_r.brightness_percent <= PERCENT_UNITY;
      cfg_r.saturation_percent <= PERCENT_UNITY;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_DEPTH:    cfg_r.color_depth_mode   <= cfg_data[1:0];
        REG_PALETTE:  cfg_r.palette_limits     <= cfg_data[3:0];
        REG_GAIN_R:   cfg_r.gain_red           <= cfg_data;
        REG_GAIN_G:   cfg_r.gain_green         <= cfg_data;
        REG_GAIN_B:   cfg_r.gain_blue          <= cfg_data;
        REG_CONTRAST: cfg_r.contrast_percent   <= cfg_data;
        REG_BRIGHT:   cfg_r.brightness_percent <= cfg_data;
        REG_SAT:      cfg_r.saturation_percent <= cfg_data;
        default:      cfg_r.saturation_percent <= cfg_r.saturation_percent;
      endcase
    end
  end

  // Front: quantize, mask, gain, contrast; classify bypass versus HSV
  pcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // Decouple the two halves
  pcc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // Back: HSV round trip and output register
  pcc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
